[rtl/core/serial_frame_crc_checker_unit_defines.svh]
// Assertion macros for the serial frame CRC checker.
// No dependencies; taken in by files that carry concurrent checks.
`ifndef SERIAL_FRAME_CRC_CHECKER_UNIT_DEFINES_SVH
`define SERIAL_FRAME_CRC_CHECKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is held.
`define SFCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sfcc: assertion failed");
// Clocked check that also holds during reset.
`define SFCC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sfcc: assertion failed");
`else
`define SFCC_ASSERT(label, clk, rst_n, prop)
`define SFCC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[rtl/core/sfcc_pkg.sv]
// Shared types, constants and the byte-wise CRC-16 update for the frame checker.
// No dependencies.
package sfcc_pkg;

    localparam int MAX_FRAME_DEF = 256;

    localparam logic [7:0]  HDR_SYNC   = 8'hA5;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_R = 16'hA001;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_LEN = 2'd1,
        ST_CRC = 2'd2,
        ST_HDR = 2'd3
    } t_status;

    // Reflected Modbus CRC, one byte: eight narrow shift/xor steps.
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_R;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/serial_frame_crc_checker_unit.sv]
// Channel   | handshake                 | payload
// ----------+---------------------------+---------------------------------------------
// input     | i_in_valid / o_in_stall   | i_rx_byte, i_last_byte, i_expected_length
// result    | o_out_valid / i_out_stall | o_status, o_computed_crc
//
// One byte per cycle unless a last byte waits on a stalled result register: a beat sits
// in the input register, where the CRC update, length and header compares run, then the
// status lands in the result register. A result is offered once a frame's last byte has
// left the input register, later only while an earlier result is held by i_out_stall.
// Only a last byte waits on a stalled result register; other bytes keep flowing.
// Synchronous active-low reset clears handshake state, count, held bytes and CRC.
// Top level of the frame checker; depends on sfcc_pkg, sfcc_crc16 and the defines header.
`include "serial_frame_crc_checker_unit_defines.svh"

module serial_frame_crc_checker_unit
    import sfcc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_byte,
    input  logic [7:0]  i_expected_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_computed_crc
);

    localparam int CW   = $clog2(MAX_FRAME + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME);

    // input register
    logic          r_s1_valid;
    logic [7:0]    r_s1_byte;
    logic          r_s1_last;
    logic [7:0]    r_s1_exp_len;

    // frame state
    logic [CW-1:0] r_count;
    logic [7:0]    r_held0;
    logic [7:0]    r_held1;
    logic [7:0]    r_first;
    logic [7:0]    r_second;

    // result register
    logic          r_out_valid;
    t_status       r_status;
    logic [15:0]   r_crc_tx;

    logic          in_accept;
    logic          s1_fire;
    logic          last_fire;
    logic [CW-1:0] cnt_next;
    logic [15:0]   crc_upd;
    logic [15:0]   crc_tx;
    logic [15:0]   crc_rx;
    logic [7:0]    first_eff;
    logic [7:0]    second_eff;
    t_status       n_status;

    assign s1_fire    = r_s1_valid && (!r_s1_last || !r_out_valid || !i_out_stall);
    assign last_fire  = s1_fire && r_s1_last;
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    sfcc_crc16 u_crc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (s1_fire),
        .i_feed    (r_count >= CW'(2)),
        .i_clear   (r_s1_last),
        .i_byte    (r_held1),
        .o_crc_upd (crc_upd)
    );

    always_comb begin
        cnt_next   = (r_count < CNT_MAX) ? r_count + CW'(1) : CNT_MAX;
        first_eff  = (r_count == '0)     ? r_s1_byte : r_first;
        second_eff = (r_count == CW'(1)) ? r_s1_byte : r_second;
        crc_tx     = {crc_upd[7:0], crc_upd[15:8]};
        crc_rx     = {r_held0, r_s1_byte};
        if (CMPW'(cnt_next) != CMPW'(r_s1_exp_len)) begin
            n_status = ST_LEN;
        end else if (crc_rx != crc_tx) begin
            n_status = ST_CRC;
        end else if (first_eff != HDR_SYNC || second_eff != r_s1_exp_len - 8'd1) begin
            n_status = ST_HDR;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte    <= i_rx_byte;
            r_s1_last    <= i_last_byte;
            r_s1_exp_len <= i_expected_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_held0  <= '0;
            r_held1  <= '0;
            r_first  <= '0;
            r_second <= '0;
        end else if (s1_fire) begin
            if (r_s1_last) begin
                r_count  <= '0;
                r_held0  <= '0;
                r_held1  <= '0;
                r_first  <= '0;
                r_second <= '0;
            end else begin
                r_count  <= cnt_next;
                r_held0  <= r_s1_byte;
                r_held1  <= r_held0;
                r_first  <= first_eff;
                r_second <= second_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (last_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_fire) begin
            r_status <= n_status;
            r_crc_tx <= crc_tx;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_computed_crc = r_crc_tx;

    // frame state is back at its start after a last beat
    `SFCC_ASSERT(a_clear_after_last, i_clk, i_rst_n, last_fire |=> (r_count == '0 && r_held0 == '0 && r_held1 == '0))
    // a result only ever follows a processed last beat
    `SFCC_ASSERT(a_out_from_last, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(last_fire))
    // a held result is never overwritten by the next frame
    `SFCC_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_out_valid && i_out_stall) |-> !last_fire)
    // the byte count never passes the frame limit; unknown until the first reset edge
    `SFCC_ASSERT_ALWAYS(a_count_sat, i_clk, !i_rst_n || r_count <= CNT_MAX)

endmodule

[rtl/core/sfcc_crc16.sv]
// CRC-16 accumulator register with its byte-wise update.
// Depends on sfcc_pkg.
module sfcc_crc16
    import sfcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,   // a beat is processed this cycle
    input  logic        i_feed,   // fold i_byte into the CRC on this beat
    input  logic        i_clear,  // frame ends: back to the initial value
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc_upd // CRC with i_byte folded in when i_feed is set
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        o_crc_upd = i_feed ? crc16_feed(r_crc, i_byte) : r_crc;
        n_crc     = r_crc;
        if (i_step) begin
            n_crc = i_clear ? CRC_INIT : o_crc_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

endmodule
